FILE: hdl/rcst_pkg.sv
// rcst_pkg: shared types and constants for the refcounted segment table
// used by rcst_cell and refcounted_segment_table, no dependencies
package rcst_pkg;

  localparam int unsigned DEF_ENTRIES    = 64;
  localparam int unsigned DEF_COUNT_BITS = 7;

  localparam int unsigned ID_W        = 32;
  localparam int unsigned SLOT_OUT_W  = 6;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned OUT_W       = SLOT_OUT_W + STATUS_W + COUNT_OUT_W;

  localparam logic MODE_OPEN  = 1'b0;
  localparam logic MODE_CLOSE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_CREATED   = 3'd0,
    ST_ATTACHED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_INVALID   = 3'd3,
    ST_HELD      = 3'd4,
    ST_RELEASED  = 3'd5,
    ST_NOTFOUND  = 3'd6,
    ST_SATURATED = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } fsm_e;

  // flags of a lookup token moving along the cell row
  typedef struct packed {
    logic valid;
    logic hit;
    logic free_found;
  } scan_flags_t;

endpackage

FILE: hdl/rcst_cell.sv
// rcst_cell: one table entry (segment id and count) plus one stage of the lookup row
// depends on rcst_pkg
module rcst_cell
  import rcst_pkg::*;
#(
  parameter int unsigned SLOT_W = 6,
  parameter int unsigned CNT_W  = DEF_COUNT_BITS,
  parameter int unsigned INDEX  = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scan_flags_t       flags_i,
  input  logic [ID_W-1:0]   id_i,
  input  logic [SLOT_W-1:0] hit_slot_i,
  input  logic [CNT_W-1:0]  hit_cnt_i,
  input  logic [SLOT_W-1:0] free_slot_i,
  output scan_flags_t       flags_o,
  output logic [ID_W-1:0]   id_o,
  output logic [SLOT_W-1:0] hit_slot_o,
  output logic [CNT_W-1:0]  hit_cnt_o,
  output logic [SLOT_W-1:0] free_slot_o,
  input  logic              upd_we_i,
  input  logic [SLOT_W-1:0] upd_slot_i,
  input  logic [ID_W-1:0]   upd_id_i,
  input  logic [CNT_W-1:0]  upd_cnt_i
);

  localparam logic [SLOT_W-1:0] MySlot = SLOT_W'(INDEX);

  logic [ID_W-1:0]   ent_id_q;
  logic [CNT_W-1:0]  ent_cnt_q;
  scan_flags_t       flags_d, flags_q;
  logic [ID_W-1:0]   id_q;
  logic [SLOT_W-1:0] hit_slot_d, hit_slot_q;
  logic [CNT_W-1:0]  hit_cnt_d, hit_cnt_q;
  logic [SLOT_W-1:0] free_slot_d, free_slot_q;
  logic              match, take_free;

  always_comb begin
    match      = flags_i.valid && !flags_i.hit && (ent_id_q == id_i);
    take_free  = flags_i.valid && !flags_i.free_found && (ent_id_q == '0);
    flags_d    = flags_i;
    hit_slot_d = hit_slot_i;
    hit_cnt_d  = hit_cnt_i;
    free_slot_d = free_slot_i;
    if (match) begin
      flags_d.hit = 1'b1;
      hit_slot_d  = MySlot;
      hit_cnt_d   = ent_cnt_q;
    end
    if (take_free) begin
      flags_d.free_found = 1'b1;
      free_slot_d        = MySlot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q        <= id_i;
    hit_slot_q  <= hit_slot_d;
    hit_cnt_q   <= hit_cnt_d;
    free_slot_q <= free_slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_id_q  <= '0;
      ent_cnt_q <= '0;
    end else if (upd_we_i && (upd_slot_i == MySlot)) begin
      ent_id_q  <= upd_id_i;
      ent_cnt_q <= upd_cnt_i;
    end
  end

  assign flags_o     = flags_q;
  assign id_o        = id_q;
  assign hit_slot_o  = hit_slot_q;
  assign hit_cnt_o   = hit_cnt_q;
  assign free_slot_o = free_slot_q;

endmodule

FILE: hdl/refcounted_segment_table.sv
// refcounted_segment_table: a request walks a row of ENTRIES cells, one cell a cycle,
// then the hit or lowest free entry is written back, except for invalid or saturated results;
// the result is registered at the row's end, then loaded into the output register once free;
// only then is the next request taken, and the result waits there while that request walks.
// reset (async, active low) frees every entry with count zero; no clearing pass.
// depends on rcst_pkg and rcst_cell
module refcounted_segment_table
  import rcst_pkg::*;
#(
  parameter int unsigned ENTRIES    = DEF_ENTRIES,
  parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [ID_W-1:0]  s_tdata_i,   // seg_id
  input  logic             s_tuser_i,   // mode
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [OUT_W-1:0] m_tdata_o    // slot_index, status, ref_count
);

  localparam int unsigned SLOT_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = COUNT_BITS;
  localparam logic [CNT_W-1:0] CntMax = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CntOne = CNT_W'(1);

  scan_flags_t       flags_w     [ENTRIES+1];
  logic [ID_W-1:0]   id_w        [ENTRIES+1];
  logic [SLOT_W-1:0] hit_slot_w  [ENTRIES+1];
  logic [CNT_W-1:0]  hit_cnt_w   [ENTRIES+1];
  logic [SLOT_W-1:0] free_slot_w [ENTRIES+1];
  logic [ENTRIES-1:0] token_w;

  fsm_e state_q, state_d;
  logic accept;
  logic mode_q;
  logic [ID_W-1:0] id_q;
  logic res_hit_q, res_free_q;
  logic [SLOT_W-1:0] res_slot_q, res_free_slot_q;
  logic [CNT_W-1:0] res_cnt_q;

  logic out_free, load_out;
  logic upd_we;
  logic [SLOT_W-1:0] upd_slot;
  logic [ID_W-1:0] upd_id;
  logic [CNT_W-1:0] upd_cnt;
  status_e status;
  logic [SLOT_W-1:0] slot_sel;
  logic [CNT_W-1:0] cnt_sel;
  logic [31:0] slot_ext, cnt_ext;

  logic m_valid_q;
  logic [OUT_W-1:0] m_data_q;

  assign accept = s_tvalid_i && s_tready_o;

  assign flags_w[0]     = '{valid: accept, hit: 1'b0, free_found: 1'b0};
  assign id_w[0]        = s_tdata_i;
  assign hit_slot_w[0]  = '0;
  assign hit_cnt_w[0]   = '0;
  assign free_slot_w[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    rcst_cell #(
      .SLOT_W (SLOT_W),
      .CNT_W  (CNT_W),
      .INDEX  (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .flags_i     (flags_w[g]),
      .id_i        (id_w[g]),
      .hit_slot_i  (hit_slot_w[g]),
      .hit_cnt_i   (hit_cnt_w[g]),
      .free_slot_i (free_slot_w[g]),
      .flags_o     (flags_w[g+1]),
      .id_o        (id_w[g+1]),
      .hit_slot_o  (hit_slot_w[g+1]),
      .hit_cnt_o   (hit_cnt_w[g+1]),
      .free_slot_o (free_slot_w[g+1]),
      .upd_we_i    (upd_we),
      .upd_slot_i  (upd_slot),
      .upd_id_i    (upd_id),
      .upd_cnt_i   (upd_cnt)
    );
    assign token_w[g] = flags_w[g+1].valid;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (flags_w[ENTRIES].valid) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    s_tready_o = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      S_IDLE:  s_tready_o = 1'b1;
      S_SCAN:  s_tready_o = 1'b0;
      S_DONE:  load_out   = out_free;
      default: s_tready_o = 1'b0;
    endcase
  end

  assign out_free = !m_valid_q || m_tready_i;

  // decision on the scan result
  always_comb begin
    upd_we   = 1'b0;
    upd_slot = res_slot_q;
    upd_id   = id_q;
    upd_cnt  = res_cnt_q;
    status   = ST_INVALID;
    slot_sel = '0;
    cnt_sel  = '0;
    if (id_q == '0) begin
      status = ST_INVALID;
    end else if (mode_q == MODE_OPEN) begin
      if (res_hit_q) begin
        slot_sel = res_slot_q;
        if (res_cnt_q == CntMax) begin
          status  = ST_SATURATED;
          cnt_sel = CntMax;
        end else begin
          status  = ST_ATTACHED;
          cnt_sel = res_cnt_q + CntOne;
          upd_we  = 1'b1;
          upd_cnt = res_cnt_q + CntOne;
        end
      end else if (res_free_q) begin
        status   = ST_CREATED;
        slot_sel = res_free_slot_q;
        cnt_sel  = CntOne;
        upd_we   = 1'b1;
        upd_slot = res_free_slot_q;
        upd_cnt  = CntOne;
      end else begin
        status = ST_FULL;
      end
    end else begin
      if (res_hit_q) begin
        slot_sel = res_slot_q;
        upd_we   = 1'b1;
        if (res_cnt_q <= CntOne) begin
          status  = ST_RELEASED;
          upd_id  = '0;
          upd_cnt = '0;
        end else begin
          status  = ST_HELD;
          cnt_sel = res_cnt_q - CntOne;
          upd_cnt = res_cnt_q - CntOne;
        end
      end else begin
        status = ST_NOTFOUND;
      end
    end
    upd_we = upd_we && load_out;
  end

  assign slot_ext = 32'(slot_sel);
  assign cnt_ext  = 32'(cnt_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= s_tuser_i;
      id_q   <= s_tdata_i;
    end
    if (flags_w[ENTRIES].valid) begin
      res_hit_q       <= flags_w[ENTRIES].hit;
      res_free_q      <= flags_w[ENTRIES].free_found;
      res_slot_q      <= hit_slot_w[ENTRIES];
      res_cnt_q       <= hit_cnt_w[ENTRIES];
      res_free_slot_q <= free_slot_w[ENTRIES];
    end
    if (load_out) begin
      m_data_q <= {cnt_ext[COUNT_OUT_W-1:0], status, slot_ext[SLOT_OUT_W-1:0]};
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

`ifndef ASSERT_OFF
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(token_w))
    else $error("more than one lookup in the cell row");

  a_end_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_w[ENTRIES].valid |-> state_q == S_SCAN)
    else $error("lookup left the row outside a scan");

  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_tvalid_o)
    else $error("result beat lost");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_we |-> state_q == S_DONE && id_q != '0)
    else $error("entry written outside write-back");
`endif

endmodule

FILE: test/refcounted_segment_table_test.sv
// refcounted_segment_table_test: self-checking stream testbench for the segment table,
// predicting slot, status and count per request and checking them beat by beat.
// depends on rcst_pkg and refcounted_segment_table
module refcounted_segment_table_test;
  import rcst_pkg::*;

  localparam int unsigned ENTRIES        = DEF_ENTRIES;
  localparam int unsigned COUNT_BITS     = DEF_COUNT_BITS;
  localparam int unsigned COUNT_MAX      = (1 << COUNT_BITS) - 1;
  localparam int unsigned CLK_HALF       = 4;
  localparam int unsigned POOL_SIZE      = 96;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_LIMIT    = 20000;
  localparam int unsigned SETTLE_CYCLES  = 2 * ENTRIES + 8;
  localparam int unsigned TIMEOUT_CYCLES = 1500000;

  // slot in the lowest bits, as on m_tdata_o
  typedef struct packed {
    logic [COUNT_OUT_W-1:0] count;
    status_e                status;
    logic [SLOT_OUT_W-1:0]  slot;
  } seg_result_t;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             s_tvalid_i = 1'b0;
  logic             s_tready_o;
  logic [ID_W-1:0]  s_tdata_i  = '0;   // seg_id
  logic             s_tuser_i  = MODE_OPEN;   // mode
  logic             m_tvalid_o;
  logic             m_tready_i = 1'b0;
  logic [OUT_W-1:0] m_tdata_o;   // slot_index, status, ref_count

  logic [ID_W-1:0]       tbl_id   [ENTRIES];
  logic [COUNT_BITS-1:0] tbl_refs [ENTRIES];
  logic [ID_W-1:0]       id_pool  [POOL_SIZE];
  seg_result_t           pending_results [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asks      = 0;
  int unsigned hold_taken     = 0;
  int unsigned hold_left      = 0;
  int unsigned errors         = 0;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned seen_status [8];

  refcounted_segment_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  initial begin
    for (int k = 0; k < ENTRIES; k++) begin
      tbl_id[k]   = '0;
      tbl_refs[k] = '0;
    end
    for (int k = 0; k < 8; k++) begin
      seen_status[k] = 0;
    end
  end

  function automatic seg_result_t predict_lookup(input logic mode, input logic [ID_W-1:0] id);
    seg_result_t res;
    int          hit;
    int          free_slot;
    res        = '0;
    res.status = ST_INVALID;
    hit        = -1;
    free_slot  = -1;
    if (id == '0) begin
      return res;
    end
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (tbl_id[k] == id) hit = k;
      if (tbl_id[k] == '0) free_slot = k;
    end
    if (mode == MODE_OPEN) begin
      if (hit >= 0) begin
        res.slot = SLOT_OUT_W'(hit);
        if (tbl_refs[hit] == COUNT_MAX) begin
          res.status = ST_SATURATED;
        end else begin
          tbl_refs[hit] = tbl_refs[hit] + COUNT_BITS'(1);
          res.status    = ST_ATTACHED;
        end
        res.count = COUNT_OUT_W'(tbl_refs[hit]);
      end else if (free_slot >= 0) begin
        tbl_id[free_slot]   = id;
        tbl_refs[free_slot] = COUNT_BITS'(1);
        res.slot            = SLOT_OUT_W'(free_slot);
        res.count           = COUNT_OUT_W'(1);
        res.status          = ST_CREATED;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      if (hit >= 0) begin
        res.slot = SLOT_OUT_W'(hit);
        if (tbl_refs[hit] <= 1) begin
          tbl_refs[hit] = '0;
          tbl_id[hit]   = '0;
          res.status    = ST_RELEASED;
        end else begin
          tbl_refs[hit] = tbl_refs[hit] - COUNT_BITS'(1);
          res.status    = ST_HELD;
          res.count     = COUNT_OUT_W'(tbl_refs[hit]);
        end
      end else begin
        res.status = ST_NOTFOUND;
      end
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_beat(input logic [OUT_W-1:0] data);
    seg_result_t got;
    seg_result_t want;
    got = data;
    results_seen++;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected beat: expected none, actual slot %0d status %0d count %0d",
               $time, got.slot, got.status, got.count);
    end else begin
      want = pending_results.pop_front();
      seen_status[want.status]++;
      compare_field("slot_index", 32'(want.slot), 32'(got.slot));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("ref_count", 32'(want.count), 32'(got.count));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) check_beat(m_tdata_o);
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_asks != hold_taken) begin
      hold_taken <= hold_asks;
      hold_left  <= HOLD_CYCLES;
      m_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic send_item(input logic mode, input logic [ID_W-1:0] id);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= mode;
    s_tdata_i  <= id;
    do @(posedge clk_i); while (!s_tready_o);
    pending_results.push_back(predict_lookup(mode, id));
    items_sent++;
  endtask

  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    s_tvalid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending_results.size() != 0 && waited < DRAIN_LIMIT);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: expected %0d more beats, actual none", $time, pending_results.size());
    end
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_item(MODE_OPEN, '0);
    send_item(MODE_CLOSE, '0);
    send_item(MODE_CLOSE, 32'hFFFF_FFFF);
    send_item(MODE_OPEN, 32'hFFFF_FFFF);
    send_item(MODE_OPEN, 32'hFFFF_FFFF);
    send_item(MODE_OPEN, 32'h0000_0001);
    send_item(MODE_OPEN, 32'h8000_0000);
    send_item(MODE_CLOSE, 32'hFFFF_FFFF);
    send_item(MODE_CLOSE, 32'hFFFF_FFFF);
    send_item(MODE_CLOSE, 32'hFFFF_FFFF);
    // slot zero is free again and must be reused
    send_item(MODE_OPEN, 32'h5A5A_5A5A);
    send_item(MODE_OPEN, 32'hA5A5_A5A5);
    send_item(MODE_OPEN, '0);
    send_item(MODE_CLOSE, 32'h0000_0001);
    send_item(MODE_CLOSE, 32'h8000_0000);
    send_item(MODE_CLOSE, 32'h5A5A_5A5A);
    send_item(MODE_CLOSE, 32'hA5A5_A5A5);
    send_item(MODE_CLOSE, 32'h7FFF_FFFF);
    wait_drained();
  endtask

  task automatic test_table_full();
    logic [ID_W-1:0] ids [ENTRIES];
    set_idling(0, 0);
    for (int k = 0; k < ENTRIES; k++) begin
      ids[k] = ($urandom() << 7) | 32'h40 | ID_W'(k);
      if (k == 8) hold_asks <= hold_asks + 1;
      send_item(MODE_OPEN, ids[k]);
    end
    repeat (3) send_item(MODE_OPEN, $urandom() | 32'h1);
    send_item(MODE_OPEN, ids[ENTRIES-1]);
    for (int k = 0; k < ENTRIES; k++) begin
      send_item(MODE_CLOSE, ids[k]);
    end
    send_item(MODE_CLOSE, ids[ENTRIES-1]);
    send_item(MODE_CLOSE, ids[0]);
    wait_drained();
  endtask

  task automatic test_saturation();
    logic [ID_W-1:0] id;
    set_idling(14, 14);
    id = $urandom() | 32'h1;
    repeat (COUNT_MAX + 3) send_item(MODE_OPEN, id);
    repeat (COUNT_MAX + 1) send_item(MODE_CLOSE, id);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned count, input int unsigned send_pct,
                             input int unsigned recv_pct, input int unsigned open_pct);
    int unsigned     pick;
    logic            mode;
    logic [ID_W-1:0] id;
    set_idling(send_pct, recv_pct);
    repeat (count) begin
      pick = $urandom_range(99);
      mode = ($urandom_range(99) < open_pct) ? MODE_OPEN : MODE_CLOSE;
      if (pick < 3) begin
        id = '0;
      end else if (pick < 9) begin
        id = $urandom();
      end else begin
        id = id_pool[$urandom_range(POOL_SIZE - 1)];
      end
      send_item(mode, id);
    end
    wait_drained();
  endtask

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("refcounted_segment_table_test failed");
    $finish;
  end

  initial begin
    id_pool[0] = 32'hFFFF_FFFF;
    id_pool[1] = 32'h0000_0001;
    id_pool[2] = 32'h8000_0000;
    id_pool[3] = 32'h7FFF_FFFF;
    for (int k = 4; k < POOL_SIZE; k++) begin
      id_pool[k] = $urandom() | 32'h100;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_saturation();
    test_random(350, 0, 0, 55);
    test_random(350, 74, 0, 70);
    test_random(350, 0, 74, 40);
    test_random(350, 14, 14, 60);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("ran %0d requests, %0d beats back: %0d created, %0d attached, %0d held, %0d released",
             items_sent, results_seen, seen_status[ST_CREATED], seen_status[ST_ATTACHED],
             seen_status[ST_HELD], seen_status[ST_RELEASED]);
    $display("edge cases: %0d full, %0d saturated, %0d not found, %0d invalid id",
             seen_status[ST_FULL], seen_status[ST_SATURATED], seen_status[ST_NOTFOUND],
             seen_status[ST_INVALID]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("refcounted_segment_table_test passed");
    end else begin
      $display("refcounted_segment_table_test failed");
    end
    $finish;
  end

endmodule
